@@ rtl/space_time_reservation_table_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the space-time reservation table
// Same-cycle and next-cycle implications, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SPACE_TIME_RESERVATION_TABLE_ASSERT_SVH
`define SPACE_TIME_RESERVATION_TABLE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define STT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stt assertion failed");

// consequent holds in the cycle after the antecedent
`define STT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stt assertion failed");

`endif

@@ rtl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and field widths of the space-time reservation table.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    localparam int LOC_FW   = 10;
    localparam int T_FW     = 8;
    localparam int AGENT_FW = 8;
    localparam int HOLD_FW  = 9;
    localparam int LOC_SPAN = 1 << LOC_FW;
    localparam int T_SPAN   = 1 << T_FW;

    typedef enum logic [1:0] {
        ACT_RESERVE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_MOVE    = 2'd2,
        ACT_HOLD    = 2'd3
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [AGENT_FW-1:0]   agent;
        logic [LOC_FW-1:0]     location;
        logic [LOC_FW-1:0]     from_location;
        logic [T_FW-1:0]       timestep;
    } t_cmd;

    typedef struct packed {
        logic                  blocked;
        logic                  vertex_hit;
        logic [AGENT_FW-1:0]   vertex_agent;
        logic                  swap_hit;
        logic [AGENT_FW-1:0]   swap_agent;
        logic [HOLD_FW-1:0]    free_from;
    } t_result;

    // one grid word: occupied flag and occupying agent
    typedef struct packed {
        logic                  valid;
        logic [AGENT_FW-1:0]   agent;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/stt_grid.sv @@
// ----------------------------------------------------------------------------
// stt_grid
// Single-port occupancy memory, one word per (location, timestep), with a
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_grid
    import stt_pkg::*;
#(
    parameter int ADDR_W = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire t_entry            i_wdata,
    output t_entry                 o_rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/stt_ctrl.sv @@
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: clearing sweep, reserve write, release read-modify-write of one
// grid word, three-read move check and backward row scan for hold queries.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ctrl
    import stt_pkg::*;
#(
    parameter int NUM_LOCATIONS = 1024,
    parameter int NUM_TIMESTEPS = 256,
    parameter int NUM_AGENTS    = 256,
    parameter int LOC_W         = 10,
    parameter int T_W           = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [T_FW-1:0]       i_cfg_wr_data,
    output logic                       o_mem_we,
    output logic [LOC_W+T_W-1:0]       o_mem_addr,
    output t_entry                     o_mem_wdata,
    input  wire t_entry                i_mem_rdata,
    output logic                       o_done,
    output t_result                    o_result
);

    localparam int ADDR_W = LOC_W + T_W;
    localparam int T_USED = (NUM_TIMESTEPS < T_SPAN) ? NUM_TIMESTEPS : T_SPAN;
    localparam logic [T_W-1:0] T_LAST = T_W'(T_USED - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REL,
        S_MV_PREV,
        S_MV_FROM,
        S_MV_DONE,
        S_HOLD
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [T_FW-1:0]       r_horizon, n_horizon;
    logic [ADDR_W-1:0]     r_clr, n_clr;
    logic [T_W-1:0]        r_k, n_k;
    t_entry                r_dst, n_dst;
    t_entry                r_prev, n_prev;
    logic                  r_done, n_done;
    t_result               r_result, n_result;

    logic [LOC_FW-1:0]     loc_sel;
    logic [T_FW-1:0]       t_sel;
    logic                  use_clr;
    t_entry                from_e;
    logic [HOLD_FW-1:0]    last_p1;
    logic [HOLD_FW-1:0]    t_ext;

    function automatic logic f_loc_ok(input logic [LOC_FW-1:0] loc);
        return 32'(loc) < NUM_LOCATIONS;
    endfunction

    function automatic logic f_t_ok(input logic [T_FW-1:0] ts);
        return 32'(ts) < NUM_TIMESTEPS;
    endfunction

    // horizon, agent range and grid bounds gate reserve and release
    function automatic logic f_allowed(input t_cmd cmd, input logic [T_FW-1:0] hz);
        return (hz == '0 || cmd.timestep <= hz) && (32'(cmd.agent) < NUM_AGENTS) &&
               f_loc_ok(cmd.location) && f_t_ok(cmd.timestep);
    endfunction

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_horizon = i_cfg_wr_en ? i_cfg_wr_data : r_horizon;
        n_clr     = r_clr;
        n_k       = r_k;
        n_dst     = r_dst;
        n_prev    = r_prev;
        n_done    = 1'b0;
        n_result  = r_result;
        o_mem_we    = 1'b0;
        o_mem_wdata = '0;
        loc_sel   = r_cmd.location;
        t_sel     = r_cmd.timestep;
        use_clr   = 1'b0;
        from_e    = '0;
        t_ext     = HOLD_FW'(r_cmd.timestep);
        last_p1   = HOLD_FW'(r_k) + HOLD_FW'(1);

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we = 1'b1;
                use_clr  = 1'b1;
                n_clr    = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                loc_sel = i_cmd.location;
                t_sel   = i_cmd.timestep;
                if (i_start) begin
                    n_cmd    = i_cmd;
                    n_result = '0;
                    unique case (i_cmd.action)
                        ACT_RESERVE: begin
                            o_mem_we          = f_allowed(i_cmd, r_horizon);
                            o_mem_wdata.valid = 1'b1;
                            o_mem_wdata.agent = i_cmd.agent;
                            n_done            = 1'b1;
                        end
                        ACT_RELEASE: n_state = S_REL;
                        ACT_MOVE:    n_state = S_MV_PREV;
                        ACT_HOLD: begin
                            if (f_loc_ok(i_cmd.location)) begin
                                t_sel   = T_FW'(T_LAST);
                                n_k     = T_LAST;
                                n_state = S_HOLD;
                            end else begin
                                n_result.free_from = HOLD_FW'(i_cmd.timestep);
                                n_done             = 1'b1;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_REL: begin
                // clear only when this agent holds the step
                if (f_allowed(r_cmd, r_horizon) && i_mem_rdata.valid &&
                    i_mem_rdata.agent == r_cmd.agent) begin
                    o_mem_we = 1'b1;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_MV_PREV: begin
                n_dst   = (f_loc_ok(r_cmd.location) && f_t_ok(r_cmd.timestep)) ?
                          i_mem_rdata : '0;
                t_sel   = r_cmd.timestep - T_FW'(1);
                n_state = S_MV_FROM;
            end
            S_MV_FROM: begin
                // no earlier step at time zero
                n_prev  = (f_loc_ok(r_cmd.location) && r_cmd.timestep != '0 &&
                           f_t_ok(r_cmd.timestep - T_FW'(1))) ? i_mem_rdata : '0;
                loc_sel = r_cmd.from_location;
                n_state = S_MV_DONE;
            end
            S_MV_DONE: begin
                from_e = (f_loc_ok(r_cmd.from_location) && f_t_ok(r_cmd.timestep)) ?
                         i_mem_rdata : '0;
                n_result.vertex_hit   = r_dst.valid;
                n_result.vertex_agent = r_dst.valid ? r_dst.agent : '0;
                n_result.swap_hit     = r_prev.valid && (from_e == r_prev);
                n_result.swap_agent   = (r_prev.valid && (from_e == r_prev)) ?
                                        r_prev.agent : '0;
                n_result.blocked      = r_dst.valid || (r_prev.valid && (from_e == r_prev));
                n_result.free_from    = '0;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_HOLD: begin
                // r_k is the timestep whose word arrives this cycle
                if (i_mem_rdata.valid) begin
                    n_result.free_from = (last_p1 > t_ext) ? last_p1 : t_ext;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_k == '0) begin
                    n_result.free_from = t_ext;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k   = r_k - T_W'(1);
                    t_sel = T_FW'(r_k - T_W'(1));
                end
            end
            default: n_state = S_CLEAR;
        endcase

        o_mem_addr = use_clr ? r_clr : {loc_sel[LOC_W-1:0], t_sel[T_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_k      <= n_k;
        r_dst    <= n_dst;
        r_prev   <= n_prev;
        r_result <= n_result;
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_horizon <= '0;
            r_clr     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_horizon <= n_horizon;
            r_clr     <= n_clr;
            r_done    <= n_done;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ rtl/space_time_reservation_table.sv @@
// Reserve writes at accept; release reads the word and clears it if the agent
// holds it; a move check reads the destination, previous step and source in
// turn; a hold query scans its row backward, one read per cycle. A new beat
// is taken in the cycle the previous result shows. Reset: a clearing sweep
// writes all 2**(LOC_W+T_W) grid words (262144 at defaults) with busy high;
// the horizon resets to 0. Results cannot be stalled.
// ----------------------------------------------------------------------------
// space_time_reservation_table
// Occupancy grid of (location, timestep) with reserve, release, move conflict
// check and hold-time query.
// ----------------------------------------------------------------------------
`default_nettype none

module space_time_reservation_table
    import stt_pkg::*;
#(
    parameter int NUM_LOCATIONS = 1024,
    parameter int NUM_TIMESTEPS = 256,
    parameter int NUM_AGENTS    = 256
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire t_cmd            i_cmd,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [T_FW-1:0] i_cfg_wr_data,
    output logic                 o_done,
    output t_result              o_result
);

    localparam int LOC_USED = (NUM_LOCATIONS < LOC_SPAN) ? NUM_LOCATIONS : LOC_SPAN;
    localparam int T_USED   = (NUM_TIMESTEPS < T_SPAN) ? NUM_TIMESTEPS : T_SPAN;
    localparam int LOC_W    = $clog2(LOC_USED);
    localparam int T_W      = $clog2(T_USED);
    localparam int ADDR_W   = LOC_W + T_W;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    t_entry            mem_wdata;
    t_entry            mem_rdata;

    stt_ctrl #(
        .NUM_LOCATIONS (NUM_LOCATIONS),
        .NUM_TIMESTEPS (NUM_TIMESTEPS),
        .NUM_AGENTS    (NUM_AGENTS),
        .LOC_W         (LOC_W),
        .T_W           (T_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_cmd         (i_cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rdata   (mem_rdata),
        .o_done        (o_done),
        .o_result      (o_result)
    );

    stt_grid #(
        .ADDR_W (ADDR_W)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/stt_chk.sv @@
// ----------------------------------------------------------------------------
// stt_chk
// Port-level checks of the reservation table results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "space_time_reservation_table_assert.svh"

module stt_chk
    import stt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire t_cmd    i_cmd,
    input  wire logic    o_done,
    input  wire t_result o_result
);

    logic acc_reserve;
    logic any_hit;
    logic agents_zero;

    assign acc_reserve = start && !busy && (i_cmd.action == ACT_RESERVE);
    assign any_hit     = o_result.vertex_hit || o_result.swap_hit;
    assign agents_zero = (o_result.vertex_agent == '0) && (o_result.swap_agent == '0);

    // reserve answers in the very next cycle
    `STT_ASSERT_NXT(a_reserve_next, i_clk, i_rst_n, acc_reserve, o_done)

    // blocked is exactly the union of both conflicts
    `STT_ASSERT_IMP(a_blocked_union, i_clk, i_rst_n, o_done, o_result.blocked == any_hit)

    // a hold answer carries no conflict flags
    `STT_ASSERT_IMP(a_hold_clean, i_clk, i_rst_n, o_done && o_result.free_from != '0, !any_hit)

    // agents read as zero without a hit
    `STT_ASSERT_IMP(a_agent_zero, i_clk, i_rst_n, o_done && !any_hit, agents_zero)

endmodule

bind space_time_reservation_table stt_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the space-time reservation table. Reserve, release,
// move-check and hold-query beats are driven through the start/busy handshake.
// A scoreboard keeps its own occupancy grid and horizon and predicts every
// result strobe, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import stt_pkg::*;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 300;
    // the clearing sweep after reset is the longest quiet stretch
    localparam int QUIET_LIMIT     = 800_000;
    // a hold query on an empty row scans every timestep of the row
    localparam int DRAIN_CYCLES    = 300;

    // ------------------------------------------------------------------------
    class grid_scoreboard;
        t_entry     cells [LOC_SPAN*T_SPAN];
        logic [7:0] horizon;
        t_result    expected_q [$];
        int         errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            horizon = '0;
            errors  = 0;
        endfunction

        function void set_horizon(input logic [7:0] h);
            horizon = h;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string field, input logic [8:0] got,
                    input logic [8:0] want);
            errors++;
            $display("tb_top: mismatch at %0t on %s: got %0d, want %0d",
                     $time, field, got, want);
        endtask

        // apply one accepted beat to the grid and queue its outcome
        function void apply_command(input t_cmd c);
            t_result    r;
            t_entry     prev;
            t_entry     src;
            logic [17:0] idx;
            int         last_plus;
            r   = '0;
            idx = {c.location, c.timestep};
            case (c.action)
                ACT_RESERVE, ACT_RELEASE: begin
                    if (horizon == 8'd0 || c.timestep <= horizon) begin
                        if (c.action == ACT_RESERVE) begin
                            cells[idx] = '{valid: 1'b1, agent: c.agent};
                        end else if (cells[idx].valid && cells[idx].agent == c.agent) begin
                            cells[idx] = '0;
                        end
                    end
                end
                ACT_MOVE: begin
                    if (cells[idx].valid) begin
                        r.vertex_hit   = 1'b1;
                        r.vertex_agent = cells[idx].agent;
                    end
                    // no step before time zero, so no swap there
                    if (c.timestep != 8'd0) begin
                        prev = cells[{c.location, 8'(c.timestep - 8'd1)}];
                        src  = cells[{c.from_location, c.timestep}];
                        if (prev.valid && src.valid && src.agent == prev.agent) begin
                            r.swap_hit   = 1'b1;
                            r.swap_agent = prev.agent;
                        end
                    end
                    r.blocked = r.vertex_hit | r.swap_hit;
                end
                default: begin
                    last_plus = 0;
                    for (int k = T_SPAN; k > 0; k--) begin
                        if (cells[{c.location, 8'(k - 1)}].valid) begin
                            last_plus = k;
                            break;
                        end
                    end
                    r.free_from = (last_plus > int'(c.timestep)) ? 9'(last_plus)
                                                                 : {1'b0, c.timestep};
                end
            endcase
            expected_q = {expected_q, r};
        endfunction

        task check_outcome(input t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report("unexpected result", 9'd1, 9'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.blocked !== want.blocked)
                report("blocked", 9'(got.blocked), 9'(want.blocked));
            if (got.vertex_hit !== want.vertex_hit)
                report("vertex_hit", 9'(got.vertex_hit), 9'(want.vertex_hit));
            if (got.vertex_agent !== want.vertex_agent)
                report("vertex_agent", 9'(got.vertex_agent), 9'(want.vertex_agent));
            if (got.swap_hit !== want.swap_hit)
                report("swap_hit", 9'(got.swap_hit), 9'(want.swap_hit));
            if (got.swap_agent !== want.swap_agent)
                report("swap_agent", 9'(got.swap_agent), 9'(want.swap_agent));
            if (got.free_from !== want.free_from)
                report("free_from", got.free_from, want.free_from);
        endtask
    endclass

    // ------------------------------------------------------------------------
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       start         = 1'b0;
    t_cmd       i_cmd         = '0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = '0;
    logic       busy;
    logic       o_done;
    t_result    o_result;

    grid_scoreboard grid_sb;
    int             quiet_cycles = 0;

    logic [9:0] loc_pool [8];
    logic [7:0] agent_pool [4];
    logic [7:0] t_base;

    space_time_reservation_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_done        (o_done),
        .o_result      (o_result)
    );

    always #5 i_clk = ~i_clk;

    // result check first: a strobe always belongs to an older beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                grid_sb.check_outcome(o_result);
            if (start && !busy)
                grid_sb.apply_command(i_cmd);
            if (i_cfg_wr_en)
                grid_sb.set_horizon(i_cfg_wr_data);
        end
        if (o_done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    function automatic t_cmd make_cmd(input t_action act, input logic [7:0] agent,
                                      input logic [9:0] loc, input logic [9:0] from,
                                      input logic [7:0] t);
        t_cmd c;
        c.action        = act;
        c.agent         = agent;
        c.location      = loc;
        c.from_location = from;
        c.timestep      = t;
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[$bits(t_cmd)-1:0];
    endfunction

    function automatic logic [9:0] pool_loc();
        return loc_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [7:0] pool_time();
        return 8'(t_base + 8'($urandom_range(0, 7)));
    endfunction

    // a small working set keeps paths dense enough to collide
    task automatic refresh_pools(input logic [7:0] h);
        int pick;
        foreach (loc_pool[i]) begin
            pick = $urandom_range(0, 9);
            loc_pool[i] = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023
                                               : 10'($urandom_range(0, 1023));
        end
        foreach (agent_pool[i]) begin
            pick = $urandom_range(0, 9);
            agent_pool[i] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255
                                                : 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 5);
        if (h != 8'd0 && pick < 3)
            t_base = (h < 8'd4) ? 8'd0 : (h > 8'd252) ? 8'd248 : 8'(h - 8'd4);
        else if (pick == 3)
            t_base = 8'd0;
        else if (pick == 4)
            t_base = 8'd248;
        else
            t_base = 8'($urandom_range(0, 248));
    endtask

    task automatic drive_cmd(input t_cmd c, input int gap_pct);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_cmd <= random_cmd();
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (grid_sb.pending() != 0) @(posedge i_clk);
    endtask

    // only written with the table idle and nothing in flight
    task automatic load_horizon(input logic [7:0] h);
        @(negedge i_clk);
        start <= 1'b0;
        wait_drained();
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= h;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'($urandom);
    endtask

    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] h;
        logic [7:0] a;
        logic [7:0] t;
        int         sent;
        int         refresh_at;
        int         gap_pct;
        int         pick;
        int         len;

        grid_sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: grid corners, swap edge, same-cell move, wrong-agent release
        drive_cmd(make_cmd(ACT_RESERVE, 8'd0,   10'd0,    10'd0,    8'd0),   20);
        drive_cmd(make_cmd(ACT_RESERVE, 8'd255, 10'd1023, 10'd0,    8'd255), 20);
        drive_cmd(make_cmd(ACT_MOVE,    8'd0,   10'd0,    10'd1023, 8'd0),   20);
        drive_cmd(make_cmd(ACT_RESERVE, 8'd7,   10'd5,    10'd0,    8'd9),   20);
        drive_cmd(make_cmd(ACT_RESERVE, 8'd7,   10'd6,    10'd0,    8'd10),  20);
        drive_cmd(make_cmd(ACT_MOVE,    8'd0,   10'd5,    10'd6,    8'd10),  20);
        drive_cmd(make_cmd(ACT_MOVE,    8'd0,   10'd6,    10'd6,    8'd10),  20);
        drive_cmd(make_cmd(ACT_MOVE,    8'd0,   10'd1023, 10'd1023, 8'd255), 20);
        drive_cmd(make_cmd(ACT_HOLD,    8'd0,   10'd1023, 10'd0,    8'd0),   20);
        drive_cmd(make_cmd(ACT_HOLD,    8'd0,   10'd0,    10'd0,    8'd255), 20);
        drive_cmd(make_cmd(ACT_HOLD,    8'd0,   10'd300,  10'd0,    8'd17),  20);
        drive_cmd(make_cmd(ACT_HOLD,    8'd0,   10'd5,    10'd0,    8'd0),   20);
        drive_cmd(make_cmd(ACT_RELEASE, 8'd8,   10'd5,    10'd0,    8'd9),   20);
        drive_cmd(make_cmd(ACT_MOVE,    8'd0,   10'd5,    10'd6,    8'd10),  20);
        drive_cmd(make_cmd(ACT_RELEASE, 8'd7,   10'd5,    10'd0,    8'd9),   20);
        drive_cmd(make_cmd(ACT_MOVE,    8'd0,   10'd5,    10'd6,    8'd10),  20);
        drive_cmd(make_cmd(ACT_RELEASE, 8'd7,   10'd5,    10'd0,    8'd9),   20);
        drive_cmd(make_cmd(ACT_RESERVE, 8'd255, 10'd1023, 10'd0,    8'd254), 20);
        drive_cmd(make_cmd(ACT_MOVE,    8'd0,   10'd1023, 10'd1023, 8'd255), 20);

        // short horizon: steps past it are dropped
        load_horizon(8'd3);
        drive_cmd(make_cmd(ACT_RESERVE, 8'd1, 10'd2, 10'd0, 8'd4), 20);
        drive_cmd(make_cmd(ACT_RESERVE, 8'd1, 10'd2, 10'd0, 8'd3), 20);
        drive_cmd(make_cmd(ACT_HOLD,    8'd0, 10'd2, 10'd0, 8'd0), 20);
        drive_cmd(make_cmd(ACT_RELEASE, 8'd1, 10'd2, 10'd0, 8'd4), 20);
        drive_cmd(make_cmd(ACT_MOVE,    8'd0, 10'd2, 10'd2, 8'd4), 20);
        drive_cmd(make_cmd(ACT_RELEASE, 8'd1, 10'd2, 10'd0, 8'd3), 20);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       h = 8'd255;
                1:       h = 8'd1;
                4:       h = 8'd0;
                default: h = 8'($urandom_range(2, 254));
            endcase
            load_horizon(h);
            sent       = 0;
            refresh_at = 0;
            gap_pct    = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (sent >= refresh_at) begin
                    refresh_pools(h);
                    refresh_at = sent + 100;
                    // last phase runs back to back; elsewhere mix calm and gappy stretches
                    gap_pct = (ph == NUM_PHASES - 1) ? 0 :
                              ($urandom_range(0, 3) == 0) ? 0 : 30;
                end
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    // one agent's path over consecutive steps
                    a   = agent_pool[$urandom_range(0, 3)];
                    t   = pool_time();
                    len = $urandom_range(2, 5);
                    for (int s = 0; s < len && int'(t) + s <= 255; s++) begin
                        drive_cmd(make_cmd(ACT_RESERVE, a, pool_loc(), 10'($urandom),
                                           8'(int'(t) + s)), gap_pct);
                        sent++;
                    end
                end else begin
                    if (pick < 55)
                        drive_cmd(make_cmd(ACT_MOVE, 8'($urandom), pool_loc(), pool_loc(),
                                           pool_time()), gap_pct);
                    else if (pick < 67)
                        drive_cmd(make_cmd(ACT_RELEASE, agent_pool[$urandom_range(0, 3)],
                                           pool_loc(), 10'($urandom), pool_time()),
                                  gap_pct);
                    else if (pick < 80)
                        drive_cmd(make_cmd(ACT_HOLD, 8'($urandom), pool_loc(),
                                           10'($urandom),
                                           ($urandom_range(0, 1) == 0) ? pool_time()
                                                                       : 8'($urandom)),
                                  gap_pct);
                    else
                        drive_cmd(random_cmd(), gap_pct);
                    sent++;
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (grid_sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
